// File: src/kwm_pkg.sv
package kwm_pkg;

  // Store geometry
  localparam int MAX_LISTS  = 8;
  localparam int LIST_DEPTH = 256;
  localparam int LIST_W     = $clog2(MAX_LISTS);
  localparam int POS_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W     = LIST_W + POS_W;
  localparam int STORE_N    = MAX_LISTS * LIST_DEPTH;
  localparam int TREE_LVLS  = LIST_W;
  localparam int TREE_N     = 2 ** LIST_W;

  // Word fields
  localparam int VAL_W   = 32;
  localparam int SEL_W   = 3;
  localparam int CFG_W   = 4;
  localparam int TDATA_W = 40;
  localparam int PAD_W   = TDATA_W - VAL_W - SEL_W;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_POP    = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_FILL
  } state_t;

  // One list head as seen by the selection tree
  typedef struct packed {
    logic                     valid;
    logic [LIST_W-1:0]        idx;
    logic signed [VAL_W-1:0]  value;
  } head_t;

endpackage

// File: src/k_way_sorted_merge.sv
// Channel   Dir  Handshake              Payload
// in_       in   in_tvalid/in_tready    tdata: list_select, value; tuser: opcode
// out_      out  out_tvalid/out_tready  tdata: merged_value, source_list; tuser: status
// cfg_      in   cfg_valid/cfg_ready    cfg_data: lists_in_use
//
// Append, clear and unused opcodes complete in ST_IDLE. A pop whose list still holds
// unread elements also passes through ST_FILL, which loads the popped list's head
// register from the element RAM's registered read port; in_tready is low then.
// Reset clears fill counts, read positions and lists_in_use at once; the element
// RAM is not cleared. A new input word is taken only while the result slot is empty
// or its word is taken at the same edge; with that slot full and not taken, in_tready
// drops.
module k_way_sorted_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [kwm_pkg::TDATA_W-1:0]  in_tdata,   // list_select[2:0], value[34:3]
  input  logic [1:0]                   in_tuser,   // opcode[1:0]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [kwm_pkg::TDATA_W-1:0]  out_tdata,  // merged_value[31:0], source_list[34:32]
  output logic [1:0]                   out_tuser,  // status[1:0]
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [kwm_pkg::CFG_W-1:0]    cfg_data
);
  import kwm_pkg::*;

  state_t                  state_r, state_nxt;
  logic [CFG_W-1:0]        lists_in_use_r;
  logic [CNT_W-1:0]        fc_r   [MAX_LISTS];
  logic [CNT_W-1:0]        fc_nxt [MAX_LISTS];
  logic [CNT_W-1:0]        rp_r   [MAX_LISTS];
  logic [CNT_W-1:0]        rp_nxt [MAX_LISTS];
  logic signed [VAL_W-1:0] head_r   [MAX_LISTS];
  logic signed [VAL_W-1:0] head_nxt [MAX_LISTS];
  logic [LIST_W-1:0]       fill_idx_r, fill_idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]        out_val_r, out_val_nxt;
  logic [SEL_W-1:0]        out_src_r, out_src_nxt;
  status_t                 out_stat_r, out_stat_nxt;

  logic                    ram_we, ram_re;
  logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
  logic [VAL_W-1:0]        ram_rdata;

  head_t [MAX_LISTS-1:0]   cands;
  head_t                   best;
  logic [CFG_W-1:0]        active;
  logic                    accept;
  op_t                     in_op;
  logic [SEL_W-1:0]        in_sel;
  logic [VAL_W-1:0]        in_val;
  logic [LIST_W-1:0]       sel_idx;
  logic [CNT_W-1:0]        new_rp;
  logic                    order_ok;

  assign in_op  = op_t'(in_tuser);
  assign in_sel = in_tdata[SEL_W-1:0];
  assign in_val = in_tdata[SEL_W+VAL_W-1:SEL_W];
  assign sel_idx = in_sel[LIST_W-1:0];

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_src_r, out_val_r};
  assign out_tuser  = out_stat_r;

  // Lists beyond the store count as the whole store
  assign active = (int'(lists_in_use_r) > MAX_LISTS) ? CFG_W'(MAX_LISTS) : lists_in_use_r;

  // Candidate heads: list in use and not drained
  always_comb begin
    for (int i = 0; i < MAX_LISTS; i++) begin
      cands[i].valid = (i < int'(active)) && (rp_r[i] < fc_r[i]);
      cands[i].idx   = LIST_W'(i);
      cands[i].value = head_r[i];
    end
  end

  kwm_head_select u_select (
    .heads (cands),
    .best  (best)
  );

  kwm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STORE_N)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_val),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign new_rp = rp_r[best.idx] + CNT_W'(1);

  // Next state, counters, heads and result word
  always_comb begin
    state_nxt     = state_r;
    fc_nxt        = fc_r;
    rp_nxt        = rp_r;
    head_nxt      = head_r;
    fill_idx_nxt  = fill_idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_val_nxt   = out_val_r;
    out_src_nxt   = out_src_r;
    out_stat_nxt  = out_stat_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = {sel_idx, fc_r[sel_idx][POS_W-1:0]};
    ram_raddr     = {best.idx, new_rp[POS_W-1:0]};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = '0;
          out_src_nxt   = '0;
          out_stat_nxt  = STAT_OK;
          unique case (in_op)
            OP_APPEND: begin
              if ((int'(in_sel) >= MAX_LISTS) || (fc_r[sel_idx] == CNT_W'(LIST_DEPTH))) begin
                out_stat_nxt = STAT_FULL;
              end else begin
                ram_we          = 1'b1;
                fc_nxt[sel_idx] = fc_r[sel_idx] + CNT_W'(1);
                // an empty list takes the new value as its head directly
                if (rp_r[sel_idx] == fc_r[sel_idx]) begin
                  head_nxt[sel_idx] = in_val;
                end
              end
            end
            OP_POP: begin
              if (best.valid) begin
                rp_nxt[best.idx] = new_rp;
                out_val_nxt      = best.value;
                out_src_nxt      = SEL_W'(best.idx);
                if (new_rp < fc_r[best.idx]) begin
                  ram_re       = 1'b1;
                  fill_idx_nxt = best.idx;
                  state_nxt    = ST_FILL;
                end
              end else begin
                out_stat_nxt = STAT_EXHAUSTED;
              end
            end
            OP_CLEAR: begin
              for (int i = 0; i < MAX_LISTS; i++) begin
                fc_nxt[i] = '0;
                rp_nxt[i] = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        head_nxt[fill_idx_r] = ram_rdata;
        state_nxt            = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      lists_in_use_r <= '0;
      for (int i = 0; i < MAX_LISTS; i++) begin
        fc_r[i] <= '0;
        rp_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fc_r        <= fc_nxt;
      rp_r        <= rp_nxt;
      if (cfg_valid && cfg_ready) begin
        lists_in_use_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    head_r     <= head_nxt;
    fill_idx_r <= fill_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_src_r  <= out_src_nxt;
    out_stat_r <= out_stat_nxt;
  end

  // Read position never passes fill count
  always_comb begin
    order_ok = 1'b1;
    for (int i = 0; i < MAX_LISTS; i++) begin
      if (rp_r[i] > fc_r[i]) begin
        order_ok = 1'b0;
      end
    end
  end

  a_order_ok: assert property (@(posedge clk) disable iff (!rst_n) order_ok)
    else $error("read position beyond fill count");

  a_fill_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |=> (state_r == ST_IDLE))
    else $error("head refill lasted more than one cycle");

  a_no_write_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> !ram_we)
    else $error("store write during head refill");

  a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == STAT_EXHAUSTED)) |-> (out_tdata == '0))
    else $error("exhausted pop carries nonzero data");

endmodule

// File: src/kwm_ram.sv
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/kwm_head_select.sv
module kwm_head_select (
  input  kwm_pkg::head_t [kwm_pkg::MAX_LISTS-1:0] heads,
  output kwm_pkg::head_t                          best
);
  import kwm_pkg::*;

  head_t node [TREE_LVLS+1][TREE_N];

  // Keep the left (lower index) entry unless it is invalid, or the right one is valid and strictly smaller
  function automatic head_t pick(head_t a, head_t b);
    head_t r;
    r = a;
    if (b.valid && (!a.valid || (b.value < a.value))) begin
      r = b;
    end
    return r;
  endfunction

  // Pairwise tree, log2 levels
  always_comb begin
    for (int l = 0; l <= TREE_LVLS; l++) begin
      for (int j = 0; j < TREE_N; j++) begin
        node[l][j] = '0;
      end
    end
    for (int j = 0; j < MAX_LISTS; j++) begin
      node[0][j] = heads[j];
    end
    for (int l = 0; l < TREE_LVLS; l++) begin
      for (int j = 0; j < (TREE_N >> (l + 1)); j++) begin
        node[l+1][j] = pick(node[l][2*j], node[l][2*j+1]);
      end
    end
    best = node[TREE_LVLS][0];
  end

endmodule
